@@ sv/planar_body_euler_step_top_macros.svh @@
// Assertion macros for the planar body Euler step block.
`ifndef PLANAR_BODY_EULER_STEP_TOP_MACROS_SVH
`define PLANAR_BODY_EULER_STEP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PES_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pes: implication check failed");
`define PES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pes: next-cycle check failed");
`else
`define PES_ASSERT_IMP(lbl, ante, cons)
`define PES_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/pes_pkg.sv @@
// Shared types, constants and helpers for the planar body Euler step block.
`default_nettype none
package pes_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int WORD_W       = 32;
  localparam int DT_W         = 20;
  localparam int MAG_W        = 31;
  localparam int NET_W        = WORD_W + 1;
  localparam int MUL_DIG_W    = 32;
  localparam int MUL_A_W      = 2 * MUL_DIG_W;
  localparam int MUL_B_W      = 32;
  localparam int MUL_P_W      = MUL_DIG_W + MUL_B_W + 2;
  localparam int ACC_W        = MUL_A_W + MUL_B_W;
  localparam int PROD_LIM_EXP = 60;
  localparam int PROD_W       = PROD_LIM_EXP + 2;
  localparam int SUM_W        = 64;
  localparam int CFG_IDX_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MASS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_INERTIA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_DAMPING  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_DAMPING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRICTION_FORCE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_DEADBAND   = 3'd5;

  localparam logic [WORD_W-1:0] RST_INVERSE_MASS    = 32'd65536;
  localparam logic [WORD_W-1:0] RST_INVERSE_INERTIA = 32'd65536;
  localparam logic [WORD_W-1:0] RST_LINEAR_DAMPING  = 32'd0;
  localparam logic [WORD_W-1:0] RST_ANGULAR_DAMPING = 32'd0;
  localparam logic [MAG_W-1:0]  RST_FRICTION_FORCE  = 31'd58982;
  localparam logic [MAG_W-1:0]  RST_STOP_DEADBAND   = 31'd328;

  typedef struct packed {
    logic signed [WORD_W-1:0] force_x;
    logic signed [WORD_W-1:0] force_y;
    logic signed [WORD_W-1:0] torque;
    logic [DT_W-1:0]          time_step;
  } item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] heading;
    logic signed [WORD_W-1:0] vel_x;
    logic signed [WORD_W-1:0] vel_y;
    logic signed [WORD_W-1:0] turn_rate;
    logic                     saturated;
  } result_t;

  typedef struct packed {
    logic [WORD_W-1:0] inverse_mass;
    logic [WORD_W-1:0] inverse_inertia;
    logic [WORD_W-1:0] linear_damping_rate;
    logic [WORD_W-1:0] angular_damping_rate;
    logic [MAG_W-1:0]  friction_force;
    logic [MAG_W-1:0]  stop_deadband;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_COMMIT,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_VRATE,
    OP_T1DT,
    OP_NETINV,
    OP_T2DT,
    OP_VDT
  } op_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_H
  } axis_t;

  typedef struct packed {
    logic  load_in;
    logic  mul_start;
    logic  capture;
    logic  commit;
    logic  load_out;
    axis_t axis;
    op_t   op;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic mul_done;
  } status_t;

  function automatic op_t op_next(op_t op);
    op_t n;
    case (op)
      OP_VRATE:  n = OP_T1DT;
      OP_T1DT:   n = OP_NETINV;
      OP_NETINV: n = OP_T2DT;
      OP_T2DT:   n = OP_VDT;
      default:   n = OP_VRATE;
    endcase
    return n;
  endfunction

  function automatic axis_t axis_next(axis_t ax);
    axis_t n;
    case (ax)
      AX_X:    n = AX_Y;
      AX_Y:    n = AX_H;
      default: n = AX_X;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

@@ sv/pes_mul.sv @@
// Multi-cycle signed by unsigned fixed-point multiplier with floor and saturation.
`default_nettype none
module pes_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [pes_pkg::MUL_A_W-1:0]  a,
  input  logic [pes_pkg::MUL_B_W-1:0]         b,
  output logic                                busy,
  output logic                                done,
  output logic signed [pes_pkg::PROD_W-1:0]   result
);

  localparam int DW = pes_pkg::MUL_DIG_W;
  localparam int AW = pes_pkg::ACC_W;
  localparam int PW = pes_pkg::MUL_P_W;
  localparam int LE = pes_pkg::PROD_LIM_EXP;

  localparam logic [1:0] PH_LO  = 2'd0;
  localparam logic [1:0] PH_HI  = 2'd1;
  localparam logic [1:0] PH_END = 2'd2;

  localparam logic signed [AW-1:0] LIM_HI = {{(AW-LE-1){1'b0}}, 1'b1, {LE{1'b0}}};
  localparam logic signed [AW-1:0] LIM_LO = {{(AW-LE){1'b1}}, {LE{1'b0}}};

  logic signed [pes_pkg::MUL_A_W-1:0] a_reg;
  logic [pes_pkg::MUL_B_W-1:0]        b_reg;
  logic signed [AW-1:0]               acc;
  logic [1:0]                         phase;
  logic signed [DW:0]                 x_op;
  logic signed [pes_pkg::MUL_B_W:0]   y_op;
  logic signed [PW-1:0]               prod;
  logic signed [AW-1:0]               prod_ext;
  logic signed [AW-1:0]               shifted;

  always_comb begin
    if (phase == PH_LO) begin
      x_op = {1'b0, a_reg[DW-1:0]};
    end else begin
      x_op = {a_reg[pes_pkg::MUL_A_W-1], a_reg[pes_pkg::MUL_A_W-1:DW]};
    end
    y_op     = {1'b0, b_reg};
    prod     = x_op * y_op;
    prod_ext = {{(AW-PW){prod[PW-1]}}, prod};
    shifted  = acc >>> pes_pkg::FRAC_BITS;
    if (shifted > LIM_HI) begin
      result = LIM_HI[pes_pkg::PROD_W-1:0];
    end else if (shifted < LIM_LO) begin
      result = LIM_LO[pes_pkg::PROD_W-1:0];
    end else begin
      result = shifted[pes_pkg::PROD_W-1:0];
    end
  end

  assign done = busy && (phase == PH_END);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= PH_LO;
    end else if (start) begin
      busy  <= 1'b1;
      phase <= PH_LO;
    end else if (busy) begin
      case (phase)
        PH_LO:   phase <= PH_HI;
        PH_HI:   phase <= PH_END;
        default: begin
          busy  <= 1'b0;
          phase <= PH_LO;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      b_reg <= b;
    end
    if (busy && phase == PH_LO) begin
      acc <= prod_ext;
    end else if (busy && phase == PH_HI) begin
      acc <= acc + (prod_ext <<< DW);
    end
  end

endmodule
`default_nettype wire

@@ sv/pes_dp.sv @@
// Datapath: body state, operand selection, friction, multiplier and commit logic.
`default_nettype none
module pes_dp (
  input  logic              clk,
  input  logic              rst,
  input  pes_pkg::cmd_t     cmd,
  input  pes_pkg::item_t    item,
  input  pes_pkg::cfg_t     cfg,
  output pes_pkg::status_t  status,
  output pes_pkg::result_t  result
);

  localparam int WW = pes_pkg::WORD_W;
  localparam int PW = pes_pkg::PROD_W;
  localparam int SW = pes_pkg::SUM_W;
  localparam int NW = pes_pkg::NET_W;
  localparam int AW = pes_pkg::MUL_A_W;

  localparam logic signed [SW-1:0] W_MAX = {{(SW-WW+1){1'b0}}, {(WW-1){1'b1}}};
  localparam logic signed [SW-1:0] W_MIN = {{(SW-WW+1){1'b1}}, {(WW-1){1'b0}}};

  pes_pkg::item_t        in_reg;
  pes_pkg::result_t      out_reg;
  logic signed [WW-1:0]  vel_x, vel_y, turn, pos_x, pos_y, head;
  logic signed [PW-1:0]  t1, damp, t2, drive, pm;
  logic                  sat;

  logic signed [WW-1:0]  v_sel, p_sel, u_sel;
  logic [WW-1:0]         inv_sel, rate_sel;
  logic signed [NW-1:0]  v_ext, band_ext, fmag_ext, fric, net;
  logic [pes_pkg::MUL_B_W-1:0] dt_ext;
  logic signed [AW-1:0]  mul_a;
  logic [pes_pkg::MUL_B_W-1:0] mul_b;
  logic                  mul_busy, mul_done;
  logic signed [PW-1:0]  mul_res;
  logic signed [SW-1:0]  vsum, psum;
  logic signed [WW-1:0]  v_new, p_new;
  logic                  v_ov, p_ov;

  always_comb begin
    case (cmd.axis)
      pes_pkg::AX_X: begin
        v_sel = vel_x; p_sel = pos_x; u_sel = in_reg.force_x;
        inv_sel = cfg.inverse_mass; rate_sel = cfg.linear_damping_rate;
      end
      pes_pkg::AX_Y: begin
        v_sel = vel_y; p_sel = pos_y; u_sel = in_reg.force_y;
        inv_sel = cfg.inverse_mass; rate_sel = cfg.linear_damping_rate;
      end
      default: begin
        v_sel = turn; p_sel = head; u_sel = in_reg.torque;
        inv_sel = cfg.inverse_inertia; rate_sel = cfg.angular_damping_rate;
      end
    endcase
  end

  always_comb begin
    v_ext    = {v_sel[WW-1], v_sel};
    band_ext = {2'b00, cfg.stop_deadband};
    fmag_ext = {2'b00, cfg.friction_force};
    if (v_ext > band_ext) begin
      fric = fmag_ext;
    end else if (v_ext < -band_ext) begin
      fric = -fmag_ext;
    end else begin
      fric = '0;
    end
    net    = {u_sel[WW-1], u_sel} - fric;
    dt_ext = {{(pes_pkg::MUL_B_W-pes_pkg::DT_W){1'b0}}, in_reg.time_step};
  end

  always_comb begin
    case (cmd.op)
      pes_pkg::OP_VRATE: begin
        mul_a = {{(AW-WW){v_sel[WW-1]}}, v_sel};
        mul_b = rate_sel;
      end
      pes_pkg::OP_T1DT: begin
        mul_a = {{(AW-PW){t1[PW-1]}}, t1};
        mul_b = dt_ext;
      end
      pes_pkg::OP_NETINV: begin
        mul_a = {{(AW-NW){net[NW-1]}}, net};
        mul_b = inv_sel;
      end
      pes_pkg::OP_T2DT: begin
        mul_a = {{(AW-PW){t2[PW-1]}}, t2};
        mul_b = dt_ext;
      end
      default: begin
        mul_a = {{(AW-WW){v_sel[WW-1]}}, v_sel};
        mul_b = dt_ext;
      end
    endcase
  end

  pes_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (mul_res)
  );

  assign status.mul_busy = mul_busy;
  assign status.mul_done = mul_done;

  always_comb begin
    vsum = {{(SW-WW){v_sel[WW-1]}}, v_sel} - {{(SW-PW){damp[PW-1]}}, damp}
         + {{(SW-PW){drive[PW-1]}}, drive};
    psum = {{(SW-WW){p_sel[WW-1]}}, p_sel} + {{(SW-PW){pm[PW-1]}}, pm};
    v_ov = (vsum > W_MAX) || (vsum < W_MIN);
    p_ov = (psum > W_MAX) || (psum < W_MIN);
    if (vsum > W_MAX) begin
      v_new = W_MAX[WW-1:0];
    end else if (vsum < W_MIN) begin
      v_new = W_MIN[WW-1:0];
    end else begin
      v_new = vsum[WW-1:0];
    end
    if (psum > W_MAX) begin
      p_new = W_MAX[WW-1:0];
    end else if (psum < W_MIN) begin
      p_new = W_MIN[WW-1:0];
    end else begin
      p_new = psum[WW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vel_x <= '0;
      vel_y <= '0;
      turn  <= '0;
      pos_x <= '0;
      pos_y <= '0;
      head  <= '0;
      sat   <= 1'b0;
    end else if (cmd.load_in) begin
      sat <= 1'b0;
    end else if (cmd.commit) begin
      sat <= sat | v_ov | p_ov;
      case (cmd.axis)
        pes_pkg::AX_X: begin
          vel_x <= v_new;
          pos_x <= p_new;
        end
        pes_pkg::AX_Y: begin
          vel_y <= v_new;
          pos_y <= p_new;
        end
        default: begin
          turn <= v_new;
          head <= p_new;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_reg <= item;
    end
    if (cmd.capture) begin
      case (cmd.op)
        pes_pkg::OP_VRATE:  t1    <= mul_res;
        pes_pkg::OP_T1DT:   damp  <= mul_res;
        pes_pkg::OP_NETINV: t2    <= mul_res;
        pes_pkg::OP_T2DT:   drive <= mul_res;
        default:            pm    <= mul_res;
      endcase
    end
    if (cmd.load_out) begin
      out_reg.pos_x     <= pos_x;
      out_reg.pos_y     <= pos_y;
      out_reg.heading   <= head;
      out_reg.vel_x     <= vel_x;
      out_reg.vel_y     <= vel_y;
      out_reg.turn_rate <= turn;
      out_reg.saturated <= sat;
    end
  end

  assign result = out_reg;

endmodule
`default_nettype wire

@@ sv/pes_ctrl.sv @@
// Controller: sequences the products per axis, commits state and hands off results.
`default_nettype none
module pes_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  output logic              result_valid,
  input  logic              result_stall,
  input  pes_pkg::status_t  status,
  output pes_pkg::cmd_t     cmd
);

  pes_pkg::state_t state, state_next;
  pes_pkg::axis_t  axis, axis_next;
  pes_pkg::op_t    op, op_next;
  logic            out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pes_pkg::ST_IDLE;
      axis      <= pes_pkg::AX_X;
      op        <= pes_pkg::OP_VRATE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      op        <= op_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    op_next    = op;
    cmd        = '0;
    cmd.axis   = axis;
    cmd.op     = op;
    case (state)
      pes_pkg::ST_IDLE: begin
        if (item_valid) begin
          cmd.load_in = 1'b1;
          axis_next   = pes_pkg::AX_X;
          op_next     = pes_pkg::OP_VRATE;
          state_next  = pes_pkg::ST_ISSUE;
        end
      end
      pes_pkg::ST_ISSUE: begin
        cmd.mul_start = 1'b1;
        state_next    = pes_pkg::ST_WAIT;
      end
      pes_pkg::ST_WAIT: begin
        if (status.mul_done) begin
          cmd.capture = 1'b1;
          if (op == pes_pkg::OP_VDT) begin
            state_next = pes_pkg::ST_COMMIT;
          end else begin
            op_next    = pes_pkg::op_next(op);
            state_next = pes_pkg::ST_ISSUE;
          end
        end
      end
      pes_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        op_next    = pes_pkg::OP_VRATE;
        if (axis == pes_pkg::AX_H) begin
          state_next = pes_pkg::ST_OUT;
        end else begin
          axis_next  = pes_pkg::axis_next(axis);
          state_next = pes_pkg::ST_ISSUE;
        end
      end
      pes_pkg::ST_OUT: begin
        if (!out_valid || !result_stall) begin
          cmd.load_out = 1'b1;
          state_next   = pes_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pes_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !result_stall) begin
      out_valid_next = 1'b0;
    end
  end

  assign item_stall   = (state != pes_pkg::ST_IDLE);
  assign result_valid = out_valid;

endmodule
`default_nettype wire

@@ sv/planar_body_euler_step_top.sv @@
// Planar rigid body forward Euler step with Coulomb friction, Q16.16 state.
// Items are processed one at a time: a new item is taken only in the idle state,
// after the previous result is loaded, since fifteen products go through the
// single 33x33 multiplier one after another, with one commit per axis.
// Reset (synchronous, active high): state to zero, registers to defaults,
// result register empty.
`default_nettype none
`include "planar_body_euler_step_top_macros.svh"
module planar_body_euler_step_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  pes_pkg::item_t                    item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output pes_pkg::result_t                  result,
  input  logic                              cfg_we,
  input  logic [pes_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pes_pkg::WORD_W-1:0]        cfg_data
);

  pes_pkg::cfg_t    cfg;
  pes_pkg::cmd_t    cmd;
  pes_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inverse_mass         <= pes_pkg::RST_INVERSE_MASS;
      cfg.inverse_inertia      <= pes_pkg::RST_INVERSE_INERTIA;
      cfg.linear_damping_rate  <= pes_pkg::RST_LINEAR_DAMPING;
      cfg.angular_damping_rate <= pes_pkg::RST_ANGULAR_DAMPING;
      cfg.friction_force       <= pes_pkg::RST_FRICTION_FORCE;
      cfg.stop_deadband        <= pes_pkg::RST_STOP_DEADBAND;
    end else if (cfg_we) begin
      case (cfg_index)
        pes_pkg::CFG_INVERSE_MASS:    cfg.inverse_mass         <= cfg_data;
        pes_pkg::CFG_INVERSE_INERTIA: cfg.inverse_inertia      <= cfg_data;
        pes_pkg::CFG_LINEAR_DAMPING:  cfg.linear_damping_rate  <= cfg_data;
        pes_pkg::CFG_ANGULAR_DAMPING: cfg.angular_damping_rate <= cfg_data;
        pes_pkg::CFG_FRICTION_FORCE:  cfg.friction_force <= cfg_data[pes_pkg::MAG_W-1:0];
        pes_pkg::CFG_STOP_DEADBAND:   cfg.stop_deadband  <= cfg_data[pes_pkg::MAG_W-1:0];
        default: ;
      endcase
    end
  end

  pes_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  pes_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .cfg    (cfg),
    .status (status),
    .result (result)
  );

  `PES_ASSERT_NEXT(a_busy_after_transfer, item_valid && !item_stall, item_stall)
  `PES_ASSERT_IMP(a_no_result_overwrite, cmd.load_out, !result_valid || !result_stall)
  `PES_ASSERT_IMP(a_mul_start_idle, cmd.mul_start, !status.mul_busy)

endmodule
`default_nettype wire
